// ===== sv/skvt_pkg.sv =====
// Shared types and constants for the sorted name/number table.
// Used by skvt_ram users, the top level and the port checker.
`timescale 1ns / 1ps
`default_nettype none
package skvt_pkg;

    localparam int CAPACITY  = 128;
    localparam int KEY_BYTES = 19;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int STR_W     = 152;
    localparam int ENTRY_W   = 2 * STR_W;

    // keeps the first KEY_BYTES bytes of a name, byte 0 in the top bits
    localparam logic [STR_W-1:0] KEY_MASK = ~({STR_W{1'b1}} >> (KEY_BYTES * 8));

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_FIND   = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EXISTS    = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_RANGE     = 3'd4
    } status_t;

endpackage
`default_nettype wire

// ===== sv/sorted_key_value_table.sv =====
// Top level of the sorted name/number table: sequencer, comparator, output register.
// Depends on skvt_pkg and skvt_ram.
//
//  channel | direction | handshake            | word
//  in      | into      | in_valid / in_stall  | request and name/number/index
//  out     | out of    | out_valid / out_stall| status, position, entry, count
//
// A request reads and compares each entry scanned (one RAM read, one compare),
// and reads and writes each entry moved when an add or delete shifts the table;
// scan and shift together cover at most one pass of the table. The entry RAM
// has a single read port; a read by index is one RAM read.
// Reset clears the count, so no clearing pass is needed.
// in_stall is high from acceptance until the result sits in the output
// register; a stalled result holds and the next request is still accepted.
`timescale 1ns / 1ps
`default_nettype none
module sorted_key_value_table (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic [1:0]   req_type,
    input  wire logic [63:0]  name_hi,
    input  wire logic [63:0]  name_mid,
    input  wire logic [23:0]  name_lo,
    input  wire logic [63:0]  number_hi,
    input  wire logic [63:0]  number_mid,
    input  wire logic [23:0]  number_lo,
    input  wire logic [6:0]   read_index,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic [2:0]        status,
    output logic [6:0]        position,
    output logic [63:0]       out_name_hi,
    output logic [63:0]       out_name_mid,
    output logic [23:0]       out_name_lo,
    output logic [63:0]       out_number_hi,
    output logic [63:0]       out_number_mid,
    output logic [23:0]       out_number_lo,
    output logic [7:0]        entry_count
);
    import skvt_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE      = 10'b0000000001,
        S_SCAN_RD   = 10'b0000000010,
        S_SCAN_CMP  = 10'b0000000100,
        S_DECIDE    = 10'b0000001000,
        S_UP_RD     = 10'b0000010000,
        S_UP_WR     = 10'b0000100000,
        S_DN_RD     = 10'b0001000000,
        S_DN_WR     = 10'b0010000000,
        S_READ_WAIT = 10'b0100000000,
        S_DONE      = 10'b1000000000
    } state_t;

    state_t             state_reg, state_next;
    req_t               req_reg, req_next;
    logic [STR_W-1:0]   key_reg, key_next;
    logic [STR_W-1:0]   val_reg, val_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               found_reg, found_next;
    status_t            st_reg, st_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [STR_W-1:0]   res_name_reg, res_name_next;
    logic [STR_W-1:0]   res_val_reg, res_val_next;

    logic               out_valid_reg, out_valid_next;
    logic [2:0]         out_st_reg, out_st_next;
    logic [6:0]         out_pos_reg, out_pos_next;
    logic [STR_W-1:0]   out_name_reg, out_name_next;
    logic [STR_W-1:0]   out_val_reg, out_val_next;
    logic [7:0]         out_cnt_reg, out_cnt_next;

    logic               rd_en, wr_en;
    logic [IDX_W-1:0]   rd_addr, wr_addr;
    logic [ENTRY_W-1:0] rd_data, wr_data;
    logic [STR_W-1:0]   entry_key;

    skvt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign entry_key = rd_data[ENTRY_W-1:STR_W];

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        found_next     = found_reg;
        st_next        = st_reg;
        pos_next       = pos_reg;
        res_name_next  = res_name_reg;
        res_val_next   = res_val_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_st_next    = out_st_reg;
        out_pos_next   = out_pos_reg;
        out_name_next  = out_name_reg;
        out_val_next   = out_val_reg;
        out_cnt_next   = out_cnt_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = idx_reg[IDX_W-1:0];
        wr_data        = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next      = req_t'(req_type);
                    key_next      = {name_hi, name_mid, name_lo} & KEY_MASK;
                    val_next      = {number_hi, number_mid, number_lo};
                    idx_next      = '0;
                    found_next    = 1'b0;
                    st_next       = ST_OK;
                    pos_next      = '0;
                    res_name_next = '0;
                    res_val_next  = '0;
                    if (req_t'(req_type) == REQ_READ)
                    begin
                        if (32'(read_index) < 32'(cnt_reg))
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = IDX_W'(read_index);
                            pos_next   = IDX_W'(read_index);
                            state_next = S_READ_WAIT;
                        end
                        else
                        begin
                            st_next    = ST_RANGE;
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_SCAN_CMP;
                end
            end
            // stop at the first entry not below the key
            S_SCAN_CMP:
            begin
                if (key_reg == entry_key)
                begin
                    found_next = 1'b1;
                    state_next = S_DECIDE;
                end
                else if (key_reg < entry_key)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_DECIDE:
            begin
                state_next = S_DONE;
                case (req_reg)
                    REQ_ADD:
                    begin
                        if (found_reg)
                        begin
                            st_next  = ST_EXISTS;
                            pos_next = idx_reg[IDX_W-1:0];
                        end
                        else if (32'(cnt_reg) >= CAPACITY)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            pos_next   = idx_reg[IDX_W-1:0];
                            idx_next   = cnt_reg;
                            state_next = S_UP_RD;
                        end
                    end
                    REQ_FIND:
                    begin
                        if (found_reg)
                        begin
                            pos_next     = idx_reg[IDX_W-1:0];
                            res_val_next = rd_data[STR_W-1:0];
                        end
                        else
                        begin
                            st_next = ST_NOT_FOUND;
                        end
                    end
                    REQ_DELETE:
                    begin
                        if (found_reg)
                        begin
                            pos_next   = idx_reg[IDX_W-1:0];
                            state_next = S_DN_RD;
                        end
                        else
                        begin
                            st_next = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        st_next = ST_RANGE;
                    end
                endcase
            end
            // open a gap at the insert position, top entry first
            S_UP_RD:
            begin
                if (idx_reg == CNT_W'(pos_reg))
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg;
                    wr_data    = {key_reg, val_reg};
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = IDX_W'(idx_reg - 1'b1);
                    state_next = S_UP_WR;
                end
            end
            S_UP_WR:
            begin
                wr_en      = 1'b1;
                idx_next   = idx_reg - 1'b1;
                state_next = S_UP_RD;
            end
            // close the gap left by the deleted entry
            S_DN_RD:
            begin
                if (CNT_W'(idx_reg + 1'b1) >= cnt_reg)
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = IDX_W'(idx_reg + 1'b1);
                    state_next = S_DN_WR;
                end
            end
            S_DN_WR:
            begin
                wr_en      = 1'b1;
                idx_next   = idx_reg + 1'b1;
                state_next = S_DN_RD;
            end
            S_READ_WAIT:
            begin
                res_name_next = entry_key;
                res_val_next  = rd_data[STR_W-1:0];
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_st_next    = st_reg;
                    out_pos_next   = 7'(pos_reg);
                    out_name_next  = res_name_reg;
                    out_val_next   = res_val_reg;
                    out_cnt_next   = 8'(cnt_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and output word registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        idx_reg      <= idx_next;
        found_reg    <= found_next;
        st_reg       <= st_next;
        pos_reg      <= pos_next;
        res_name_reg <= res_name_next;
        res_val_reg  <= res_val_next;
        out_st_reg   <= out_st_next;
        out_pos_reg  <= out_pos_next;
        out_name_reg <= out_name_next;
        out_val_reg  <= out_val_next;
        out_cnt_reg  <= out_cnt_next;
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = out_st_reg;
    assign position       = out_pos_reg;
    assign out_name_hi    = out_name_reg[151:88];
    assign out_name_mid   = out_name_reg[87:24];
    assign out_name_lo    = out_name_reg[23:0];
    assign out_number_hi  = out_val_reg[151:88];
    assign out_number_mid = out_val_reg[87:24];
    assign out_number_lo  = out_val_reg[23:0];
    assign entry_count    = out_cnt_reg;

endmodule
`default_nettype wire

// ===== sv/skvt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module skvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/skvt_checker.sv =====
// Port-level checks for the sorted name/number table, bound to the top level.
// Depends on skvt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module skvt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [2:0]  status,
    input wire logic [6:0]  position,
    input wire logic [7:0]  entry_count
);
    import skvt_pkg::*;

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(entry_count))
        else $error("result changed while stalled");

    // count never exceeds the table size
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(entry_count) <= CAPACITY)
        else $error("entry count beyond capacity");

    // status is one of the defined codes
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_RANGE)
        else $error("undefined status code");

    // failed lookups, full-table adds and out-of-range reads report position zero
    a_fail_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NOT_FOUND || status == ST_FULL || status == ST_RANGE)
        |-> position == 7'd0)
        else $error("nonzero position on failure");

endmodule

bind sorted_key_value_table skvt_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .position    (position),
    .entry_count (entry_count)
);
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the sorted name/number table.
// Drives add, find, delete and read words, checks each result against a table model.
// Depends on skvt_pkg and the sorted_key_value_table RTL.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import skvt_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 4 * CAPACITY + 20;
    localparam int RANDOM_ITEMS   = 160;
    localparam int NAME_POOL      = 40;

    typedef struct packed {
        logic [1:0]  req;
        logic [63:0] nh;
        logic [63:0] nm;
        logic [23:0] nl;
        logic [63:0] vh;
        logic [63:0] vm;
        logic [23:0] vl;
        logic [6:0]  idx;
    } request_s;

    typedef struct packed {
        logic [2:0]  st;
        logic [6:0]  pos;
        logic [63:0] onh;
        logic [63:0] onm;
        logic [23:0] onl;
        logic [63:0] ovh;
        logic [63:0] ovm;
        logic [23:0] ovl;
        logic [7:0]  cnt;
    } answer_s;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] req_type = '0;
    logic [63:0] name_hi = '0, name_mid = '0, number_hi = '0, number_mid = '0;
    logic [23:0] name_lo = '0, number_lo = '0;
    logic [6:0] read_index = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [2:0] status;
    logic [6:0] position;
    logic [63:0] out_name_hi, out_name_mid, out_number_hi, out_number_mid;
    logic [23:0] out_name_lo, out_number_lo;
    logic [7:0] entry_count;

    sorted_key_value_table DUT (.*);

    always #2 clk = ~clk;

    // table model: names and numbers as 152-bit strings
    logic [STR_W-1:0] model_names [CAPACITY];
    logic [STR_W-1:0] model_numbers [CAPACITY];
    int model_count = 0;
    answer_s expected_answers [$];
    logic [STR_W-1:0] name_pool [NAME_POOL];
    bit failed = 1'b0;
    bit stim_done = 1'b0;
    int idle_cycles = 0;
    int rx_wait = 0;

    function automatic answer_s predict_table(request_s r);
        answer_s a;
        logic [STR_W-1:0] key;
        int hit;
        int at;
        a = '0;
        key = {r.nh, r.nm, r.nl} & KEY_MASK;
        hit = -1;
        if (r.req != REQ_READ)
            for (int i = 0; i < model_count; i++)
                if (hit < 0 && model_names[i] == key) hit = i;
        case (req_t'(r.req))
            REQ_ADD:
            begin
                if (hit >= 0)
                begin
                    a.st = ST_EXISTS;
                    a.pos = hit[6:0];
                end
                else if (model_count >= CAPACITY) a.st = ST_FULL;
                else
                begin
                    at = model_count;
                    for (int i = model_count - 1; i >= 0; i--)
                        if (key < model_names[i]) at = i;
                    for (int i = model_count; i > at; i--)
                    begin
                        model_names[i] = model_names[i-1];
                        model_numbers[i] = model_numbers[i-1];
                    end
                    model_names[at] = key;
                    model_numbers[at] = {r.vh, r.vm, r.vl};
                    model_count++;
                    a.pos = at[6:0];
                end
            end
            REQ_FIND:
            begin
                if (hit >= 0)
                begin
                    a.pos = hit[6:0];
                    {a.ovh, a.ovm, a.ovl} = model_numbers[hit];
                end
                else a.st = ST_NOT_FOUND;
            end
            REQ_DELETE:
            begin
                if (hit >= 0)
                begin
                    for (int i = hit; i + 1 < model_count; i++)
                    begin
                        model_names[i] = model_names[i+1];
                        model_numbers[i] = model_numbers[i+1];
                    end
                    model_count--;
                    a.pos = hit[6:0];
                end
                else a.st = ST_NOT_FOUND;
            end
            default:
            begin
                if (r.idx < model_count)
                begin
                    a.pos = r.idx;
                    {a.onh, a.onm, a.onl} = model_names[r.idx];
                    {a.ovh, a.ovm, a.ovl} = model_numbers[r.idx];
                end
                else a.st = ST_RANGE;
            end
        endcase
        a.cnt = model_count[7:0];
        return a;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic request_s random_request();
        request_s r;
        int pick;
        r.req = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 9);
        if (pick < 8) {r.nh, r.nm, r.nl} = name_pool[$urandom_range(0, NAME_POOL - 1)];
        else {r.nh, r.nm, r.nl} = {rand64(), rand64(), 24'($urandom)};
        {r.vh, r.vm, r.vl} = {rand64(), rand64(), 24'($urandom)};
        r.idx = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 45));
        return r;
    endfunction

    // send one word, waiting out a random gap first
    task automatic send_word(request_s r);
        int gap;
        gap = $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        {req_type, name_hi, name_mid, name_lo, number_hi, number_mid, number_lo,
         read_index} <= r;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_answers.push_back(predict_table(r));
    endtask

    task automatic check_directed(answer_s want);
        answer_s got;
        got = expected_answers[$];
        if (got !== want)
        begin
            $error("directed answer: expected %h actual prediction %h", want, got);
            failed = 1'b1;
        end
    endtask

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            answer_s w;
            if (expected_answers.size() == 0)
            begin
                $error("unexpected result word");
                failed = 1'b1;
            end
            else
            begin
                w = expected_answers.pop_front();
                if (status !== w.st)
                begin $error("status exp %h act %h", w.st, status); failed = 1; end
                if (position !== w.pos)
                begin $error("position exp %h act %h", w.pos, position); failed = 1; end
                if (out_name_hi !== w.onh)
                begin $error("out_name_hi exp %h act %h", w.onh, out_name_hi); failed = 1; end
                if (out_name_mid !== w.onm)
                begin $error("out_name_mid exp %h act %h", w.onm, out_name_mid); failed = 1; end
                if (out_name_lo !== w.onl)
                begin $error("out_name_lo exp %h act %h", w.onl, out_name_lo); failed = 1; end
                if (out_number_hi !== w.ovh)
                begin
                    $error("out_number_hi exp %h act %h", w.ovh, out_number_hi);
                    failed = 1;
                end
                if (out_number_mid !== w.ovm)
                begin
                    $error("out_number_mid exp %h act %h", w.ovm, out_number_mid);
                    failed = 1;
                end
                if (out_number_lo !== w.ovl)
                begin
                    $error("out_number_lo exp %h act %h", w.ovl, out_number_lo);
                    failed = 1;
                end
                if (entry_count !== w.cnt)
                begin
                    $error("entry_count exp %h act %h", w.cnt, entry_count);
                    failed = 1;
                end
            end
        end
    end

    // receiver stall: a fresh random wait, drawn as each result word is taken, stalls the next one
    always @(posedge clk)
    begin
        int w;
        w = rx_wait;
        if (out_valid && !out_stall) w = $urandom_range(0, 10);
        else if (out_valid && w > 0) w = w - 1;
        rx_wait <= w;
        out_stall <= (w != 0);
    end

    // watchdog on accepted words
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)
            || (stim_done && expected_answers.size() == 0)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    request_s directed [$];
    answer_s directed_want [$];
    bit directed_known [$];

    initial
    begin
        request_s r;
        answer_s a;
        logic [STR_W-1:0] all_ones;
        all_ones = '1;
        for (int i = 0; i < NAME_POOL; i++)
            name_pool[i] = {rand64(), rand64(), 24'($urandom)};
        name_pool[0] = '0;
        name_pool[1] = all_ones;

        // directed table: empty reads and misses, extremes, duplicates, out-of-range reads
        r = '0; r.req = REQ_READ; r.idx = 7'd0;
        a = '0; a.st = ST_RANGE; directed.push_back(r); directed_want.push_back(a);
        directed_known.push_back(1);
        r = '0; r.req = REQ_FIND; a = '0; a.st = ST_NOT_FOUND;
        directed.push_back(r); directed_want.push_back(a); directed_known.push_back(1);
        r = '0; r.req = REQ_DELETE; r.nh = '1; a = '0; a.st = ST_NOT_FOUND;
        directed.push_back(r); directed_want.push_back(a); directed_known.push_back(1);
        r = '0; r.req = REQ_ADD; r.vh = '1; r.vm = '1; r.vl = '1;
        a = '0; a.cnt = 8'd1; directed.push_back(r); directed_want.push_back(a);
        directed_known.push_back(1);
        r.req = REQ_ADD; a = '0; a.st = ST_EXISTS; a.cnt = 8'd1;
        directed.push_back(r); directed_want.push_back(a); directed_known.push_back(1);
        r = '1; r.req = REQ_ADD; r.vh = '0; r.vm = '0; r.vl = '0;
        a = '0; a.pos = 7'd1; a.cnt = 8'd2;
        directed.push_back(r); directed_want.push_back(a); directed_known.push_back(1);
        r = '1; r.req = REQ_FIND; directed.push_back(r); directed_want.push_back('0);
        directed_known.push_back(0);
        r = '0; r.req = REQ_READ; r.idx = 7'd0; directed.push_back(r);
        directed_want.push_back('0); directed_known.push_back(0);
        r.idx = 7'd127; a = '0; a.st = ST_RANGE; a.cnt = 8'd2;
        directed.push_back(r); directed_want.push_back(a); directed_known.push_back(1);
        r = '0; r.req = REQ_DELETE; a = '0; a.cnt = 8'd1;
        directed.push_back(r); directed_want.push_back(a); directed_known.push_back(1);
        r = '0; r.req = REQ_READ; directed.push_back(r); directed_want.push_back('0);
        directed_known.push_back(0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_word(directed[i]);
            if (directed_known[i]) check_directed(directed_want[i]);
        end

        // fill the table to capacity, probe full, read the last entry, then delete in the middle and down to 30
        while (model_count < CAPACITY)
        begin
            r = random_request(); r.req = REQ_ADD;
            {r.nh, r.nm, r.nl} = {rand64(), rand64(), 24'($urandom)};
            send_word(r);
        end
        r = random_request(); r.req = REQ_ADD; r.nh = rand64() | 64'h1;
        send_word(r);
        r = '0; r.req = REQ_READ; r.idx = 7'd127; send_word(r);
        r = '0; r.req = REQ_DELETE; {r.nh, r.nm, r.nl} = model_names[64]; send_word(r);
        r = '0; r.req = REQ_DELETE; {r.nh, r.nm, r.nl} = model_names[0]; send_word(r);
        while (model_count > 30)
        begin
            r = '0; r.req = REQ_DELETE;
            {r.nh, r.nm, r.nl} = model_names[$urandom_range(0, model_count - 1)];
            send_word(r);
        end

        // random part, mostly pool names so hits are common
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_word(random_request());

        in_valid <= 1'b0;
        stim_done = 1'b1;
        while (expected_answers.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failed)
            $display("RESULT: ERROR");
        else
            $display("RESULT: OK");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
sv/skvt_pkg.sv
sv/skvt_ram.sv
sv/sorted_key_value_table.sv
sv/skvt_checker.sv
tb/sv/testbench.sv
